/* hdl/psfrb_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the failure-rate blocker.
package psfrb_pkg;

   localparam int TABLE_ENTRIES_DEF   = 16;
   localparam int TIMES_PER_ENTRY_DEF = 8;
   localparam int MAX_RESULTS         = 16;
   localparam logic [31:0] STALE_AGE  = 32'd86400;   // one day

   // event kinds
   localparam logic [1:0] KIND_FAIL  = 2'd0;
   localparam logic [1:0] KIND_SWEEP = 2'd1;
   localparam logic [1:0] KIND_AGE   = 2'd2;

   // result actions
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_FAST    = 3'd1;
   localparam logic [2:0] ACT_SLOW    = 3'd2;
   localparam logic [2:0] ACT_ALLOW   = 3'd3;
   localparam logic [2:0] ACT_IGNORE  = 3'd4;
   localparam logic [2:0] ACT_FULL    = 3'd5;
   localparam logic [2:0] ACT_UNBLOCK = 3'd6;
   localparam logic [2:0] ACT_BELOW   = 3'd7;

   // register indexes
   localparam logic [2:0] CSR_FAST_THR  = 3'd0;
   localparam logic [2:0] CSR_SLOW_THR  = 3'd1;
   localparam logic [2:0] CSR_FAST_WIN  = 3'd2;
   localparam logic [2:0] CSR_SLOW_WIN  = 3'd3;
   localparam logic [2:0] CSR_BLK_DUR   = 3'd4;
   localparam logic [2:0] CSR_ALLOW_NET = 3'd5;
   localparam logic [2:0] CSR_ALLOW_PFX = 3'd6;

   typedef struct packed {
      logic latch;
      logic search_step;
      logic alloc;
      logic found;
      logic emit_full;
      logic touch;
      logic lift_e;
      logic emit_ignore;
      logic prune_rd;
      logic prune_wr;
      logic sl_clear;
      logic shift_rd;
      logic shift_wr;
      logic append;
      logic decide;
      logic sweep_lift;
      logic sweep_step;
      logic sweep_end;
      logic age_move;
      logic age_adv;
      logic age_skip;
      logic copy_rd;
      logic copy_wr;
      logic age_end;
      logic emit_nop;
   } cmd_type;

   typedef struct packed {
      logic match;
      logic scan_end;
      logic full;
      logic blk;
      logic exp_e;
      logic prune_end;
      logic win_full;
      logic shift_end;
      logic sweep_exp;
      logic sweep_stop;
      logic age_keep;
      logic age_move;
      logic copy_last;
   } status_type;

endpackage

/* hdl/psfrb_ctrl.sv */
// Sequencer state machine for the failure-rate blocker.
module psfrb_ctrl import psfrb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic [1:0] req_kind,
   input  status_type st,
   output cmd_type    cmd,
   output logic       busy
);

   typedef enum logic [15:0] {
      S_IDLE     = 16'h0001,
      S_F_SEARCH = 16'h0002,
      S_F_CHECK  = 16'h0004,
      S_F_PR_RD  = 16'h0008,
      S_F_PR_WR  = 16'h0010,
      S_F_SH_RD  = 16'h0020,
      S_F_SH_WR  = 16'h0040,
      S_F_APPEND = 16'h0080,
      S_F_DECIDE = 16'h0100,
      S_S_SCAN   = 16'h0200,
      S_S_END    = 16'h0400,
      S_A_SCAN   = 16'h0800,
      S_A_CP_RD  = 16'h1000,
      S_A_CP_WR  = 16'h2000,
      S_A_END    = 16'h4000,
      S_NOP      = 16'h8000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               priority if (req_kind == KIND_FAIL)  state_in = S_F_SEARCH;
               else if     (req_kind == KIND_SWEEP) state_in = S_S_SCAN;
               else if     (req_kind == KIND_AGE)   state_in = S_A_SCAN;
               else                                 state_in = S_NOP;
            end
         end
         S_F_SEARCH: begin
            priority if (st.scan_end) begin
               if (st.full) begin
                  cmd.emit_full = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  cmd.alloc = 1'b1;
                  state_in  = S_F_CHECK;
               end
            end else if (st.match) begin
               cmd.found = 1'b1;
               state_in  = S_F_CHECK;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         S_F_CHECK: begin
            cmd.touch = 1'b1;
            state_in  = S_F_PR_RD;
            if (st.blk) begin
               if (st.exp_e) begin
                  cmd.lift_e = 1'b1;
               end else begin
                  cmd.emit_ignore = 1'b1;
                  state_in        = S_IDLE;
               end
            end
         end
         S_F_PR_RD: begin
            if (st.prune_end) begin
               if (st.win_full) begin
                  cmd.sl_clear = 1'b1;
                  state_in     = S_F_SH_RD;
               end else begin
                  state_in = S_F_APPEND;
               end
            end else begin
               cmd.prune_rd = 1'b1;
               state_in     = S_F_PR_WR;
            end
         end
         S_F_PR_WR: begin
            cmd.prune_wr = 1'b1;
            state_in     = S_F_PR_RD;
         end
         S_F_SH_RD: begin
            if (st.shift_end) begin
               state_in = S_F_APPEND;
            end else begin
               cmd.shift_rd = 1'b1;
               state_in     = S_F_SH_WR;
            end
         end
         S_F_SH_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = S_F_SH_RD;
         end
         S_F_APPEND: begin
            cmd.append = 1'b1;
            state_in   = S_F_DECIDE;
         end
         S_F_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_IDLE;
         end
         S_S_SCAN: begin
            if (st.scan_end || st.sweep_stop) begin
               state_in = S_S_END;
            end else begin
               cmd.sweep_step = 1'b1;
               cmd.sweep_lift = st.sweep_exp;
            end
         end
         S_S_END: begin
            cmd.sweep_end = 1'b1;
            state_in      = S_IDLE;
         end
         S_A_SCAN: begin
            priority if (st.scan_end) begin
               state_in = S_A_END;
            end else if (!st.age_keep) begin
               cmd.age_skip = 1'b1;
            end else if (st.age_move) begin
               cmd.age_move = 1'b1;
               state_in     = S_A_CP_RD;
            end else begin
               cmd.age_adv = 1'b1;
            end
         end
         S_A_CP_RD: begin
            cmd.copy_rd = 1'b1;
            state_in    = S_A_CP_WR;
         end
         S_A_CP_WR: begin
            cmd.copy_wr = 1'b1;
            if (st.copy_last) begin
               cmd.age_adv = 1'b1;
               state_in    = S_A_SCAN;
            end else begin
               state_in = S_A_CP_RD;
            end
         end
         S_A_END: begin
            cmd.age_end = 1'b1;
            state_in    = S_IDLE;
         end
         S_NOP: begin
            cmd.emit_nop = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

/* hdl/psfrb_dp.sv */
// Datapath: source table, failure-time memory, counters, registers and result register.
module psfrb_dp import psfrb_pkg::*; #(
   parameter int TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
   parameter int TIMES_PER_ENTRY = TIMES_PER_ENTRY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  st,
   input  logic [31:0] req_source_addr,
   input  logic [31:0] req_now_seconds,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output logic        rsp_valid,
   output logic        rsp_last,
   output logic [2:0]  rsp_action,
   output logic [31:0] rsp_addr_out,
   output logic        rsp_unblocked_first,
   output logic [6:0]  rsp_fast_count,
   output logic [6:0]  rsp_slow_count,
   output logic [31:0] rsp_failures_total,
   output logic [31:0] rsp_blocked_total,
   output logic [6:0]  rsp_tracked_count
);

   localparam int TE    = TABLE_ENTRIES;
   localparam int TPE   = TIMES_PER_ENTRY;
   localparam int EW    = (TE > 1) ? $clog2(TE) : 1;
   localparam int KW    = $clog2(TE + 1);
   localparam int SW    = (TPE > 1) ? $clog2(TPE) : 1;
   localparam int CW    = $clog2(TPE + 1);
   localparam int DEPTH = TE * TPE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = $clog2(MAX_RESULTS + 1);

   function automatic logic [AW-1:0] slot_addr(input logic [EW-1:0] ent,
                                                input logic [SW-1:0] slot);
      return AW'(AW'(ent) * AW'(TPE) + AW'(slot));
   endfunction

   // config
   logic [6:0]  fast_thr_ff, slow_thr_ff;
   logic [19:0] fast_win_ff, slow_win_ff, blk_dur_ff;
   logic [31:0] allow_net_ff;
   logic [5:0]  allow_pfx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_thr_ff  <= 7'd5;
         slow_thr_ff  <= 7'd8;
         fast_win_ff  <= 20'd60;
         slow_win_ff  <= 20'd3600;
         blk_dur_ff   <= 20'd3600;
         allow_net_ff <= '0;
         allow_pfx_ff <= 6'd32;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FAST_THR:  fast_thr_ff  <= csr_wdata[6:0];
            CSR_SLOW_THR:  slow_thr_ff  <= csr_wdata[6:0];
            CSR_FAST_WIN:  fast_win_ff  <= csr_wdata[19:0];
            CSR_SLOW_WIN:  slow_win_ff  <= csr_wdata[19:0];
            CSR_BLK_DUR:   blk_dur_ff   <= csr_wdata[19:0];
            CSR_ALLOW_NET: allow_net_ff <= csr_wdata;
            CSR_ALLOW_PFX: allow_pfx_ff <= csr_wdata[5:0];
            default: ;
         endcase
      end
   end

   // per-entry table
   logic [31:0]   addr_ff   [TE];
   logic [CW-1:0] tcount_ff [TE];
   logic          blk_ff    [TE];
   logic [31:0]   blk_at_ff [TE];
   logic [31:0]   seen_ff   [TE];

   // time memory
   logic [31:0] times_mem [DEPTH];
   logic [31:0] rdata_ff;

   // sequencing and item state
   logic [31:0]   src_ff, now_ff;
   logic [KW-1:0] k_ff, d_ff, fill_ff;
   logic [EW-1:0] e_ff;
   logic [CW-1:0] sl_ff, j_ff, fcnt_ff;
   logic          first_fast_ff, uf_ff;
   logic [6:0]    fc_ff, sc_ff;
   logic [RW-1:0] cnt_ff;
   logic [31:0]   pend_ff;
   logic          pend_v_ff;
   logic [31:0]   failure_ff, block_ff;

   logic [EW-1:0] ki, di;
   logic [SW-1:0] sli;
   assign ki  = k_ff[EW-1:0];
   assign di  = d_ff[EW-1:0];
   assign sli = sl_ff[SW-1:0];

   // window checks on the registered read data
   logic [31:0] age_rd;
   logic        in_slow, in_fast;
   assign age_rd  = now_ff - rdata_ff;
   assign in_slow = (age_rd <= {12'd0, slow_win_ff});
   assign in_fast = (age_rd <= {12'd0, fast_win_ff});

   // allowlist
   logic [5:0]  pfx;
   logic [31:0] amask;
   logic        allowed;
   assign pfx     = (allow_pfx_ff > 6'd32) ? 6'd32 : allow_pfx_ff;
   assign amask   = (pfx == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - pfx));
   assign allowed = (allow_net_ff != 32'd0) && (src_ff != 32'd0) &&
                    ((src_ff & amask) == (allow_net_ff & amask));

   logic [31:0] since_blk_e, since_blk_k, since_seen_k;
   assign since_blk_e  = now_ff - blk_at_ff[e_ff];
   assign since_blk_k  = now_ff - blk_at_ff[ki];
   assign since_seen_k = now_ff - seen_ff[ki];

   always_comb begin
      st            = '0;
      st.match      = (addr_ff[ki] == src_ff);
      st.scan_end   = (k_ff >= fill_ff);
      st.full       = (fill_ff >= KW'(TE));
      st.blk        = blk_ff[e_ff];
      st.exp_e      = (since_blk_e >= {12'd0, blk_dur_ff});
      st.prune_end  = (sl_ff >= tcount_ff[e_ff]);
      st.win_full   = (j_ff == CW'(TPE));
      st.shift_end  = (sl_ff == CW'(TPE - 1));
      st.sweep_exp  = blk_ff[ki] && (since_blk_k >= {12'd0, blk_dur_ff});
      st.sweep_stop = (cnt_ff >= RW'(MAX_RESULTS));
      st.age_keep   = blk_ff[ki] || !(since_seen_k > STALE_AGE);
      st.age_move   = (d_ff != k_ff);
      st.copy_last  = (sl_ff == CW'(TPE - 1));
   end

   // memory ports
   logic          mem_rd, mem_we;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [31:0]   wr_data;

   always_comb begin
      mem_rd  = cmd.prune_rd | cmd.shift_rd | cmd.copy_rd;
      rd_addr = slot_addr(e_ff, sli);
      if (cmd.shift_rd) rd_addr = slot_addr(e_ff, SW'(sl_ff + CW'(1)));
      if (cmd.copy_rd)  rd_addr = slot_addr(ki, sli);
      mem_we  = 1'b0;
      wr_addr = slot_addr(e_ff, sli);
      wr_data = rdata_ff;
      if (cmd.prune_wr && in_slow) begin
         mem_we  = 1'b1;
         wr_addr = slot_addr(e_ff, j_ff[SW-1:0]);
      end
      if (cmd.shift_wr) mem_we = 1'b1;
      if (cmd.append) begin
         mem_we  = 1'b1;
         wr_data = now_ff;
         wr_addr = (j_ff < CW'(TPE)) ? slot_addr(e_ff, j_ff[SW-1:0])
                                     : slot_addr(e_ff, SW'(TPE - 1));
      end
      if (cmd.copy_wr) begin
         mem_we  = 1'b1;
         wr_addr = slot_addr(di, sli);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) rdata_ff <= times_mem[rd_addr];
      if (mem_we) times_mem[wr_addr] <= wr_data;
   end

   // decision
   logic [2:0] dec_act;
   logic       dec_blk;
   always_comb begin
      priority if (fc_ff >= fast_thr_ff) dec_act = ACT_FAST;
      else if     (sc_ff >= slow_thr_ff) dec_act = ACT_SLOW;
      else                               dec_act = ACT_BELOW;
      dec_blk = 1'b0;
      if (dec_act != ACT_BELOW) begin
         if (allowed) dec_act = ACT_ALLOW;
         else         dec_blk = 1'b1;
      end
   end

   logic [CW-1:0] n_new;
   assign n_new = (j_ff < CW'(TPE)) ? CW'(j_ff + CW'(1)) : CW'(TPE);

   // table and item registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff    <= '0;
         failure_ff <= '0;
         block_ff   <= '0;
      end else begin
         if (cmd.alloc) fill_ff <= KW'(fill_ff + KW'(1));
         if (cmd.age_end) fill_ff <= d_ff;
         if (cmd.append) failure_ff <= failure_ff + 32'd1;
         if (cmd.decide && dec_blk) block_ff <= block_ff + 32'd1;
      end

      if (cmd.latch) begin
         src_ff    <= req_source_addr;
         now_ff    <= req_now_seconds;
         k_ff      <= '0;
         d_ff      <= '0;
         cnt_ff    <= '0;
         pend_v_ff <= 1'b0;
      end
      if (cmd.search_step) k_ff <= KW'(k_ff + KW'(1));
      if (cmd.found) e_ff <= ki;
      if (cmd.alloc) begin
         e_ff                         <= fill_ff[EW-1:0];
         addr_ff[fill_ff[EW-1:0]]     <= src_ff;
         tcount_ff[fill_ff[EW-1:0]]   <= '0;
         blk_ff[fill_ff[EW-1:0]]      <= 1'b0;
         blk_at_ff[fill_ff[EW-1:0]]   <= '0;
      end
      if (cmd.touch) begin
         seen_ff[e_ff] <= now_ff;
         sl_ff         <= '0;
         j_ff          <= '0;
         fcnt_ff       <= '0;
         first_fast_ff <= 1'b0;
         uf_ff         <= cmd.lift_e;
      end
      if (cmd.lift_e) begin
         blk_ff[e_ff]    <= 1'b0;
         blk_at_ff[e_ff] <= '0;
         tcount_ff[e_ff] <= '0;
      end
      if (cmd.prune_wr) begin
         sl_ff <= CW'(sl_ff + CW'(1));
         if (in_slow) begin
            j_ff <= CW'(j_ff + CW'(1));
            if (in_fast) fcnt_ff <= CW'(fcnt_ff + CW'(1));
            if (sl_ff == '0) first_fast_ff <= in_fast;
         end
      end
      if (cmd.sl_clear) sl_ff <= '0;
      if (cmd.shift_wr) sl_ff <= CW'(sl_ff + CW'(1));
      if (cmd.append) begin
         tcount_ff[e_ff] <= n_new;
         sc_ff           <= 7'(n_new);
         fc_ff           <= 7'(7'(fcnt_ff) + 7'd1 -
                               7'(st.win_full && first_fast_ff));
      end
      if (cmd.decide && dec_blk) begin
         blk_ff[e_ff]    <= 1'b1;
         blk_at_ff[e_ff] <= now_ff;
      end
      if (cmd.sweep_step) k_ff <= KW'(k_ff + KW'(1));
      if (cmd.sweep_lift) begin
         blk_ff[ki]    <= 1'b0;
         blk_at_ff[ki] <= '0;
         tcount_ff[ki] <= '0;
         cnt_ff        <= RW'(cnt_ff + RW'(1));
         pend_ff       <= addr_ff[ki];
         pend_v_ff     <= 1'b1;
      end
      if (cmd.age_skip) k_ff <= KW'(k_ff + KW'(1));
      if (cmd.age_move) begin
         addr_ff[di]   <= addr_ff[ki];
         tcount_ff[di] <= tcount_ff[ki];
         blk_ff[di]    <= blk_ff[ki];
         blk_at_ff[di] <= blk_at_ff[ki];
         seen_ff[di]   <= seen_ff[ki];
         sl_ff         <= '0;
      end
      if (cmd.copy_wr && !st.copy_last) sl_ff <= CW'(sl_ff + CW'(1));
      if (cmd.age_adv) begin
         k_ff <= KW'(k_ff + KW'(1));
         d_ff <= KW'(d_ff + KW'(1));
      end
   end

   // result register
   logic        rv_ff, rl_ff, ruf_ff;
   logic [2:0]  ract_ff;
   logic [31:0] raddr_ff, rfail_ff, rblk_ff;
   logic [6:0]  rfc_ff, rsc_ff, rtrk_ff;

   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else rv_ff <= cmd.emit_full | cmd.emit_ignore | cmd.decide | cmd.sweep_end |
                    cmd.age_end | cmd.emit_nop | (cmd.sweep_lift & pend_v_ff);

      rl_ff    <= 1'b1;
      ract_ff  <= ACT_NONE;
      raddr_ff <= '0;
      ruf_ff   <= 1'b0;
      rfc_ff   <= '0;
      rsc_ff   <= '0;
      rfail_ff <= failure_ff;
      rblk_ff  <= block_ff;
      rtrk_ff  <= 7'(fill_ff);
      if (cmd.emit_full) begin
         ract_ff  <= ACT_FULL;
         raddr_ff <= src_ff;
      end
      if (cmd.emit_ignore) begin
         ract_ff  <= ACT_IGNORE;
         raddr_ff <= src_ff;
      end
      if (cmd.decide) begin
         ract_ff  <= dec_act;
         raddr_ff <= src_ff;
         ruf_ff   <= uf_ff;
         rfc_ff   <= fc_ff;
         rsc_ff   <= sc_ff;
         rblk_ff  <= block_ff + 32'(dec_blk);
      end
      if (cmd.sweep_lift) begin
         rl_ff    <= 1'b0;
         ract_ff  <= ACT_UNBLOCK;
         raddr_ff <= pend_ff;
      end
      if (cmd.sweep_end && pend_v_ff) begin
         ract_ff  <= ACT_UNBLOCK;
         raddr_ff <= pend_ff;
      end
      if (cmd.age_end) rtrk_ff <= 7'(d_ff);
   end

   assign rsp_valid           = rv_ff;
   assign rsp_last            = rl_ff;
   assign rsp_action          = ract_ff;
   assign rsp_addr_out        = raddr_ff;
   assign rsp_unblocked_first = ruf_ff;
   assign rsp_fast_count      = rfc_ff;
   assign rsp_slow_count      = rsc_ff;
   assign rsp_failures_total  = rfail_ff;
   assign rsp_blocked_total   = rblk_ff;
   assign rsp_tracked_count   = rtrk_ff;

endmodule

/* hdl/per_source_failure_rate_blocker.sv */
// Top level of the per-source failure-rate blocker: controller plus datapath.
// A failure searches the table for the source, prunes its window times, shifts them when the
//   window is full, appends the new time and decides; a sweep scans the table for expired
//   blocks, and aging compacts the table, copying the time slots of each kept entry that moves.
// Throughput: one item at a time; busy stays high until the item's last transfer is issued.
// The pace is set by the walk: the search takes one table slot a cycle, the time memory
//   one read/write pair per slot. Results are one-cycle strobes; the receiver cannot stall them.
// Reset (synchronous, active high) empties the table, zeroes the totals, restores registers.
module per_source_failure_rate_blocker import psfrb_pkg::*; #(
   parameter int TABLE_ENTRIES   = TABLE_ENTRIES_DEF,
   parameter int TIMES_PER_ENTRY = TIMES_PER_ENTRY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_source_addr,
   input  logic [31:0] req_now_seconds,
   // register write port
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   // result strobe
   output logic        rsp_valid,
   output logic        rsp_last,
   output logic [2:0]  rsp_action,
   output logic [31:0] rsp_addr_out,
   output logic        rsp_unblocked_first,
   output logic [6:0]  rsp_fast_count,
   output logic [6:0]  rsp_slow_count,
   output logic [31:0] rsp_failures_total,
   output logic [31:0] rsp_blocked_total,
   output logic [6:0]  rsp_tracked_count
);

   cmd_type    cmd;
   status_type st;

   // sequencer: walks search, prune, shift, append and decide for failures,
   // the expiry scan for sweeps and the compaction pass for aging
   psfrb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .st       (st),
      .cmd      (cmd),
      .busy     (busy)
   );

   // table, time memory, totals and the registered result
   psfrb_dp #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .TIMES_PER_ENTRY (TIMES_PER_ENTRY)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .st                  (st),
      .req_source_addr     (req_source_addr),
      .req_now_seconds     (req_now_seconds),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_valid           (rsp_valid),
      .rsp_last            (rsp_last),
      .rsp_action          (rsp_action),
      .rsp_addr_out        (rsp_addr_out),
      .rsp_unblocked_first (rsp_unblocked_first),
      .rsp_fast_count      (rsp_fast_count),
      .rsp_slow_count      (rsp_slow_count),
      .rsp_failures_total  (rsp_failures_total),
      .rsp_blocked_total   (rsp_blocked_total),
      .rsp_tracked_count   (rsp_tracked_count)
   );

endmodule
